// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the top level, spq_ctrl and spq_dp through scoped names.
`default_nettype none

package spq_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_W_DEF    = 16;
  localparam int PAYLOAD_W_DEF = 32;

  // Capacity register value after reset (clamped to DEPTH in the datapath)
  localparam int CAP_RESET = 16;

  // Operation codes carried on s_tuser
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_RESP
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;     // latch incoming item
    logic start_enq;  // cur <= tail, read slot before tail
    logic start_deq;  // read head slot
    logic set_err;    // operation rejected
    logic shift;      // move larger neighbor one slot toward tail
    logic place;      // write new entry at cur
    logic finish;     // load output register, update pointers
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_head;    // cur has reached head
    logic larger;     // neighbor priority strictly larger than new entry
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: stream ports, controller, datapath.
// Depends on spq_pkg, spq_ctrl, spq_dp (which holds spq_ram).
//
// Usage:
//   Input stream (s_*): one transaction per operation. s_tuser selects the
//   operation (0 enqueue, 1 dequeue); s_tdata carries priority and payload.
//   Output stream (m_*): exactly one result transaction per input
//   transaction, in order: the dequeued entry (flagged by m_tuser), the
//   entry count after the operation, empty/full flags and an error flag for
//   enqueue-when-full or dequeue-when-empty (such operations change nothing).
//   Configuration: cfg_we/cfg_wdata write the capacity (0 acts as 1, values
//   above DEPTH act as DEPTH); any write empties the queue. Write only idle.
// Timing:
//   Dequeue and rejected operations: accept, then the result step.
//   Enqueue: accept, one shift step per entry of larger priority it passes,
//   a place step, then the result step; the insertion shifter moves one slot
//   per cycle through the single-write, single-read slot RAM. The next
//   transaction is accepted at the edge where the result can first be taken.
//   One operation is in flight at a time; s_tready is high when the
//   sequencer is idle, even while a finished result still waits on m_tready.
//   A stalled receiver holds the result in the output register and holds
//   the next operation at its final step until the result is taken.
// Reset: queue empty, both pointers 0, capacity min(16, DEPTH), no result.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int PRIO_W    = spq_pkg::PRIO_W_DEF,
  parameter int PAYLOAD_W = spq_pkg::PAYLOAD_W_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int IN_W     = ((PRIO_W + PAYLOAD_W + 7) / 8) * 8,
  localparam int OUT_RAW_W = PRIO_W + PAYLOAD_W + CNT_W + 3,
  localparam int OUT_W    = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // capacity register
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  // operation stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // item_prio, item_payload, zero pad
  input  wire logic             s_tuser,   // func
  // result stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // out_prio, out_payload, count,
                                           // is_empty, is_full, error, zero pad
  output logic                  m_tuser    // deq_valid
);

  spq_pkg::cmd_t    cmd;
  spq_pkg::status_t sts;

  logic [PRIO_W-1:0]    out_prio;
  logic [PAYLOAD_W-1:0] out_payload;
  logic [CNT_W-1:0]     out_count;
  logic                 out_empty, out_full, out_error;
  logic [OUT_RAW_W-1:0] out_fields;

  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_func  (s_tuser),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  spq_dp #(
    .DEPTH    (DEPTH),
    .PRIO_W   (PRIO_W),
    .PAYLOAD_W(PAYLOAD_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_prio      (s_tdata[PRIO_W-1:0]),
    .in_payload   (s_tdata[PRIO_W+PAYLOAD_W-1:PRIO_W]),
    .cmd          (cmd),
    .sts          (sts),
    .out_deq_valid(m_tuser),
    .out_prio     (out_prio),
    .out_payload  (out_payload),
    .out_count    (out_count),
    .out_empty    (out_empty),
    .out_full     (out_full),
    .out_error    (out_error)
  );

  // Pack result fields from the low bit up; upper pad is zero
  assign out_fields = {out_error, out_full, out_empty, out_count, out_payload, out_prio};
  assign m_tdata    = OUT_W'(out_fields);

  // A result never reports both a dequeued entry and an error
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser && out_error))
    else $error("dequeue result flagged as error");

  // The empty flag tracks the reported count
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // An accepted operation takes the sequencer out of idle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !cfg_we) |=> !s_tready)
    else $error("sequencer stayed idle after accept");

  // Data words of a rejected or enqueue result are zero
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_prio == '0 && out_payload == '0))
    else $error("non-dequeue result carries data");

endmodule

`default_nettype wire

// ===== hdl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spq_ctrl.sv =====
// Sequencer for the sorted priority queue: handshakes and step control.
// Depends on spq_pkg (state_t, cmd_t, status_t, FUNC_* codes).
`default_nettype none

module spq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_func,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire spq_pkg::status_t sts,
  output spq_pkg::cmd_t         cmd
);

  spq_pkg::state_t state, state_next;
  logic            out_free;
  logic            place_now;

  assign out_free  = !m_tvalid || m_tready;
  assign place_now = sts.at_head || !sts.larger;
  assign s_tready  = (state == spq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (s_func == spq_pkg::FUNC_ENQ && !sts.full) begin
            state_next = spq_pkg::ST_SHIFT;
          end else begin
            state_next = spq_pkg::ST_RESP;
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        if (place_now) begin
          state_next = spq_pkg::ST_RESP;
        end
      end
      spq_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          if (s_func == spq_pkg::FUNC_DEQ) begin
            cmd.set_err   = sts.empty;
            cmd.start_deq = !sts.empty;
          end else begin
            cmd.set_err   = sts.full;
            cmd.start_enq = !sts.full;
          end
        end
      end
      spq_pkg::ST_SHIFT: begin
        cmd.place = place_now;
        cmd.shift = !place_now;
      end
      spq_pkg::ST_RESP: begin
        cmd.finish = out_free;
      end
      default: cmd = '0;
    endcase
  end

  // Output valid: set when a result is loaded, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spq_dp.sv =====
// Datapath of the sorted priority queue: ring pointers, capacity, slot RAM,
// insertion shifter and result register. Depends on spq_pkg and spq_ram.
`default_nettype none

module spq_dp #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int PRIO_W    = spq_pkg::PRIO_W_DEF,
  parameter int PAYLOAD_W = spq_pkg::PAYLOAD_W_DEF,
  localparam int PTR_W    = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CNT_W-1:0]     cfg_wdata,
  input  wire logic [PRIO_W-1:0]    in_prio,
  input  wire logic [PAYLOAD_W-1:0] in_payload,
  input  wire spq_pkg::cmd_t        cmd,
  output spq_pkg::status_t          sts,
  output logic                      out_deq_valid,
  output logic [PRIO_W-1:0]         out_prio,
  output logic [PAYLOAD_W-1:0]      out_payload,
  output logic [CNT_W-1:0]          out_count,
  output logic                      out_empty,
  output logic                      out_full,
  output logic                      out_error
);

  localparam int ENT_W = PRIO_W + PAYLOAD_W;
  localparam int CAP_INIT_I = (spq_pkg::CAP_RESET > DEPTH) ? DEPTH : spq_pkg::CAP_RESET;
  localparam logic [CNT_W-1:0] CAP_INIT = CNT_W'(CAP_INIT_I);
  localparam logic [CNT_W-1:0] CAP_MAX  = CNT_W'(DEPTH);

  logic [CNT_W-1:0]     cap;
  logic [PTR_W-1:0]     head, tail, cur;
  logic [CNT_W-1:0]     occ, occ_next;
  logic [PRIO_W-1:0]    new_prio;
  logic [PAYLOAD_W-1:0] new_payload;
  logic                 op_deq, op_err;

  logic [PTR_W-1:0]     prev, prev2, head_inc, tail_inc;
  logic                 ram_we, ram_re;
  logic [PTR_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;
  logic [PRIO_W-1:0]    rd_prio;

  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CAP_MAX) begin
      r = CAP_MAX;
    end
    return r;
  endfunction

  // One slot toward the head, wrapping at the capacity
  function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] i,
                                                 input logic [CNT_W-1:0] c);
    logic [PTR_W-1:0] r;
    r = (i == '0) ? PTR_W'(c - CNT_W'(1)) : i - PTR_W'(1);
    return r;
  endfunction

  assign prev     = step_back(cur, cap);
  assign prev2    = step_back(prev, cap);
  assign head_inc = (CNT_W'(head) + CNT_W'(1) == cap) ? '0 : head + PTR_W'(1);
  assign tail_inc = (CNT_W'(tail) + CNT_W'(1) == cap) ? '0 : tail + PTR_W'(1);
  assign rd_prio  = ram_rdata[PRIO_W-1:0];

  assign sts.full    = (occ >= cap);
  assign sts.empty   = (occ == '0);
  assign sts.at_head = (cur == head);
  assign sts.larger  = (rd_prio > new_prio);

  // Slot RAM: the shifter writes cur and prefetches the slot two back
  assign ram_we    = cmd.shift || cmd.place;
  assign ram_waddr = cur;
  assign ram_wdata = cmd.shift ? ram_rdata : {new_payload, new_prio};
  assign ram_re    = cmd.start_enq || cmd.start_deq || cmd.shift;

  always_comb begin
    priority if (cmd.start_enq) begin
      ram_raddr = step_back(tail, cap);
    end else if (cmd.start_deq) begin
      ram_raddr = head;
    end else begin
      ram_raddr = prev2;
    end
  end

  spq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    priority if (op_err) begin
      occ_next = occ;
    end else if (op_deq) begin
      occ_next = occ - CNT_W'(1);
    end else begin
      occ_next = occ + CNT_W'(1);
    end
  end

  // Ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= CAP_INIT;
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else if (cfg_we) begin
      cap  <= clamp_cap(cfg_wdata);
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else if (cmd.finish && !op_err) begin
      occ <= occ_next;
      if (op_deq) begin
        if (occ_next == '0) begin
          head <= '0;
          tail <= '0;
        end else begin
          head <= head_inc;
        end
      end else begin
        tail <= tail_inc;
      end
    end
  end

  // Item and shifter registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_prio    <= in_prio;
      new_payload <= in_payload;
      op_deq      <= cmd.start_deq;
      op_err      <= cmd.set_err;
    end
    if (cmd.start_enq) begin
      cur <= tail;
    end else if (cmd.shift) begin
      cur <= prev;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_deq_valid <= op_deq;
      out_prio      <= op_deq ? rd_prio : '0;
      out_payload   <= op_deq ? ram_rdata[ENT_W-1:PRIO_W] : '0;
      out_count     <= occ_next;
      out_empty     <= (occ_next == '0);
      out_full      <= (occ_next == cap);
      out_error     <= op_err;
    end
  end

endmodule

`default_nettype wire
